/* design/sfr_pkg.sv */
package sfr_pkg;

    // Largest payload a frame may carry, in bytes.
    localparam int unsigned MAX_PAYLOAD = 8;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned TMO_W     = 16;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned PAYLOAD_W = 64;
    localparam int unsigned CFG_IDX_W = 2;

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 80;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIMEOUT = 2'd3;

    // Configuration reset values.
    localparam logic [BYTE_W-1:0] RST_SYNC_BYTE   = 8'd22;
    localparam logic [BYTE_W-1:0] RST_START_BYTE  = 8'd2;
    localparam logic [BYTE_W-1:0] RST_END_BYTE    = 8'd3;
    localparam logic [TMO_W-1:0]  RST_GAP_TIMEOUT = 16'd100;

    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE      = 3'd0,
        ST_BUSY      = 3'd1,
        ST_BAD_START = 3'd2,
        ST_BAD_CHECK = 3'd3,
        ST_BAD_END   = 3'd4,
        ST_BAD_LEN   = 3'd5,
        ST_DONE      = 3'd6
    } t_status;

    typedef enum logic [7:0] {
        PH_SYNC1 = 8'b0000_0001,
        PH_SYNC2 = 8'b0000_0010,
        PH_START = 8'b0000_0100,
        PH_LEN   = 8'b0000_1000,
        PH_CMD   = 8'b0001_0000,
        PH_DATA  = 8'b0010_0000,
        PH_CHECK = 8'b0100_0000,
        PH_END   = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_byte;
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] end_byte;
        logic [TMO_W-1:0]  gap_timeout;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] arrival_time;
        logic [BYTE_W-1:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] frame_payload;
        logic [BYTE_W-1:0]    frame_command;
        logic [LEN_W-1:0]     frame_length;
        t_status              status;
    } t_result;

endpackage

/* design/sync_frame_receiver_xor_checksum.sv */
// Channel   Direction  Handshake               Contents
// s_axis    in         tvalid / tready         one received byte and its ms timestamp
// m_axis    out        tvalid / tready         one status result per received byte
// cfg       in         valid / ready           register index and write data
//
// Each byte transfer produces exactly one result transfer through the input and
// result registers. A new byte is taken in every cycle unless m_axis stalls.
// The per-byte work is one compare of the arrival gap against the timeout,
// one phase step and the XOR update, all between the input and result registers.
// Reset (i_rst_n low at a clock edge) returns the parser to the first sync hunt
// and loads the register defaults. A stall on m_axis holds the result register;
// the input register then fills and o_s_axis_tready drops.
module sync_frame_receiver_xor_checksum import sfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream. tdata, lowest bit first: rx_byte[7:0], arrival_time[39:8].
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // Result stream. tdata, lowest bit first: status[2:0], frame_length[6:3],
    // frame_command[14:7], frame_payload[78:15], one zero fill bit.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // Configuration writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [TMO_W-1:0]      i_cfg_data
);

    t_cfg     r_cfg;
    t_in_item in_item;
    t_in_item stage_item;
    logic     stage_valid;
    logic     take;
    t_result  result;

    // Configuration writes are always accepted, o_cfg_ready is tied high. Byte registers keep
    // the low eight bits of the written data.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_byte   <= RST_SYNC_BYTE;
            r_cfg.start_byte  <= RST_START_BYTE;
            r_cfg.end_byte    <= RST_END_BYTE;
            r_cfg.gap_timeout <= RST_GAP_TIMEOUT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SYNC_BYTE:   r_cfg.sync_byte   <= i_cfg_data[BYTE_W-1:0];
                CFG_START_BYTE:  r_cfg.start_byte  <= i_cfg_data[BYTE_W-1:0];
                CFG_END_BYTE:    r_cfg.end_byte    <= i_cfg_data[BYTE_W-1:0];
                CFG_GAP_TIMEOUT: r_cfg.gap_timeout <= i_cfg_data;
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    assign in_item.rx_byte      = i_s_axis_tdata[BYTE_W-1:0];
    assign in_item.arrival_time = i_s_axis_tdata[BYTE_W +: TIME_W];

    // The input register decouples the byte source from the parser.
    sfr_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .i_take  (take),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    // The parser holds the frame state and the result register.
    sfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (stage_valid),
        .i_item      (stage_item),
        .o_take      (take),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_result    (result)
    );

    assign o_m_axis_tdata = {1'b0, result};

endmodule

/* design/sfr_in_stage.sv */
module sfr_in_stage import sfr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    // The register refills in the same cycle that its content moves on.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* design/sfr_parser.sv */
module sfr_parser import sfr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_in_valid,
    input  t_in_item i_item,
    output logic     o_take,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_result  o_result
);

    t_phase             r_phase,  n_phase;
    logic [LEN_W-1:0]   r_length, n_length;
    logic [BYTE_W-1:0]  r_command, n_command;
    logic [LEN_W-1:0]   r_count,  n_count;
    logic [BYTE_W-1:0]  r_xor,    n_xor;
    logic [TIME_W-1:0]  r_prev_time;
    logic [BYTE_W-1:0]  r_store [MAX_PAYLOAD];
    logic               r_out_valid;
    t_result            r_result, n_result;

    logic [TIME_W-1:0]  gap;
    logic               timed_out;
    t_phase             cur_phase;
    logic [BYTE_W-1:0]  b;
    logic               store_we;
    logic [LEN_W-1:0]   count_inc;
    logic [PAYLOAD_W-1:0] payload;

    assign o_take      = i_in_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    assign b         = i_item.rx_byte;
    assign gap       = i_item.arrival_time - r_prev_time;
    assign timed_out = gap > {{(TIME_W-TMO_W){1'b0}}, i_cfg.gap_timeout};
    assign cur_phase = timed_out ? PH_SYNC1 : r_phase;
    assign count_inc = r_count + LEN_W'(1);

    // Only the bytes below the frame length are shown; the rest read as zero.
    always_comb begin
        payload = '0;
        for (int i = 0; i < MAX_PAYLOAD; i++) begin
            if (LEN_W'(i) < r_length) begin
                payload[BYTE_W*i +: BYTE_W] = r_store[i];
            end
        end
    end

    always_comb begin
        n_phase   = cur_phase;
        n_length  = r_length;
        n_command = r_command;
        n_count   = r_count;
        n_xor     = r_xor;
        store_we  = 1'b0;
        n_result  = '0;
        n_result.status = ST_IDLE;
        unique case (cur_phase)
            PH_SYNC1: begin
                if (b == i_cfg.sync_byte) begin
                    n_phase = PH_SYNC2;
                    n_result.status = ST_BUSY;
                end else begin
                    n_result.status = ST_BAD_START;
                end
            end
            PH_SYNC2: begin
                if (b == i_cfg.sync_byte) begin
                    n_phase = PH_START;
                    n_result.status = ST_BUSY;
                end else begin
                    n_phase = PH_SYNC1;
                    n_result.status = ST_BAD_START;
                end
            end
            PH_START: begin
                if (b == i_cfg.start_byte) begin
                    n_phase = PH_LEN;
                    n_xor   = '0;
                    n_result.status = ST_BUSY;
                end else begin
                    n_phase = PH_SYNC1;
                    n_result.status = ST_BAD_START;
                end
            end
            PH_LEN: begin
                if (b > BYTE_W'(MAX_PAYLOAD)) begin
                    n_phase = PH_SYNC1;
                    n_result.status = ST_BAD_LEN;
                end else begin
                    n_length = b[LEN_W-1:0];
                    n_xor    = r_xor ^ b;
                    n_phase  = PH_CMD;
                    n_result.status = ST_BUSY;
                end
            end
            PH_CMD: begin
                n_command = b;
                n_xor     = r_xor ^ b;
                n_count   = '0;
                n_phase   = (r_length == '0) ? PH_CHECK : PH_DATA;
                n_result.status = ST_BUSY;
            end
            PH_DATA: begin
                store_we = r_count < LEN_W'(MAX_PAYLOAD);
                n_count  = count_inc;
                n_xor    = r_xor ^ b;
                if (count_inc >= r_length || count_inc >= LEN_W'(MAX_PAYLOAD)) begin
                    n_phase = PH_CHECK;
                end
                n_result.status = ST_BUSY;
            end
            PH_CHECK: begin
                // The check byte is the complement of the running XOR.
                if (b == (8'hFF - r_xor)) begin
                    n_phase = PH_END;
                    n_result.status = ST_IDLE;
                end else begin
                    n_phase = PH_SYNC1;
                    n_result.status = ST_BAD_CHECK;
                end
            end
            PH_END: begin
                n_phase = PH_SYNC1;
                if (b == i_cfg.end_byte) begin
                    n_result.status        = ST_DONE;
                    n_result.frame_length  = r_length;
                    n_result.frame_command = r_command;
                    n_result.frame_payload = payload;
                end else begin
                    n_result.status = ST_BAD_END;
                end
            end
            default: begin
                n_phase = PH_SYNC1;
                n_result.status = ST_BAD_START;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SYNC1;
            r_length    <= '0;
            r_command   <= '0;
            r_count     <= '0;
            r_xor       <= '0;
            r_prev_time <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase     <= n_phase;
                r_length    <= n_length;
                r_command   <= n_command;
                r_count     <= n_count;
                r_xor       <= n_xor;
                r_prev_time <= i_item.arrival_time;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result <= n_result;
        end
        if (o_take && store_we) begin
            r_store[r_count[$clog2(MAX_PAYLOAD)-1:0]] <= b;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LEN_W'(MAX_PAYLOAD))
        else $error("payload count beyond capacity");

    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.status != ST_DONE |->
        r_result.frame_length == '0 && r_result.frame_command == '0 &&
        r_result.frame_payload == '0)
        else $error("frame fields set without a completed frame");

    a_bad_len_rehunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && n_result.status == ST_BAD_LEN |=> r_phase == PH_SYNC1)
        else $error("bad length did not return to sync hunt");

    a_done_rehunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && n_result.status == ST_DONE |=>
        r_phase == PH_SYNC1 && r_result.frame_length <= LEN_W'(MAX_PAYLOAD))
        else $error("completed frame left parser out of sync hunt");

endmodule
